### design/rut_pkg.sv
`timescale 1ns / 1ps

package rut_pkg;

  localparam int unsigned VirtualSlotsDef   = 8;
  localparam int unsigned RealRegistersDef  = 64;
  localparam int unsigned IndexBitsDef      = 20;

  // Request field widths
  localparam int unsigned ReqIndexW = 20;
  localparam int unsigned ClassW    = 3;
  localparam int unsigned MaskW     = 64;
  localparam int unsigned BitIdxW   = 6;
  localparam int unsigned CountW    = 4;

  // Operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Access modes
  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_MODIFY = 2'd2;
  localparam logic [1:0] MODE_ABSENT = 2'd3;

  typedef struct packed {
    logic [1:0]           operation;
    logic                 is_virtual;
    logic [ClassW-1:0]    reg_class;
    logic [ReqIndexW-1:0] reg_index;
    logic [1:0]           access_mode;
  } req_t;

  typedef struct packed {
    logic              mentioned;
    logic [1:0]        entry_mode;
    logic              status;
    logic [MaskW-1:0]  real_read_mask;
    logic [MaskW-1:0]  real_write_mask;
    logic [CountW-1:0] virtual_count;
  } res_t;

  typedef struct packed {
    logic               apply;
    logic               clear;
    logic               set_rd;
    logic               set_wr;
    logic               idx_ok;
    logic [BitIdxW-1:0] bit_idx;
  } mask_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } state_e;

endpackage

### design/register_usage_tracker.sv
`timescale 1ns / 1ps

// Register usage tracker for one instruction. A request is taken when start_i is high
// and busy_o is low; its result appears on res_o for exactly one cycle with valid_o high
// and cannot be held off. Clear and real-register requests, and virtual-register requests
// while the slot table is empty, go straight from accept to the apply step, whose result
// is registered onto res_o. Any other virtual-register request searches the slot table
// one entry per cycle through its single read port, over the slots in use (at most
// VirtualSlots); a hit ends the search early.
// A new request may be started in the same cycle its predecessor's result is strobed.
module register_usage_tracker
  import rut_pkg::*;
#(
  parameter int unsigned VirtualSlots  = VirtualSlotsDef,
  parameter int unsigned RealRegisters = RealRegistersDef,
  parameter int unsigned IndexBits     = IndexBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic valid_o,
  output res_t res_o
);

  localparam int unsigned KeyW  = IndexBits + ClassW;
  localparam int unsigned AddrW = (VirtualSlots > 1) ? $clog2(VirtualSlots) : 1;
  localparam int unsigned CntW  = $clog2(VirtualSlots + 1);

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [KeyW-1:0]  mem_wkey;
  logic [1:0]       mem_wmode;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [KeyW-1:0]  mem_rkey;
  logic [1:0]       mem_rmode;

  mask_cmd_t        mask_cmd;
  logic             rd_hit;
  logic             wr_hit;
  logic [MaskW-1:0] rd_mask;
  logic [MaskW-1:0] wr_mask;

  logic             mentioned;
  logic [1:0]       entry_mode;
  logic             status;
  logic [CntW-1:0]  used;

  rut_seq #(
    .VirtualSlots (VirtualSlots),
    .RealRegisters(RealRegisters),
    .IndexBits    (IndexBits),
    .KeyW         (KeyW),
    .AddrW        (AddrW),
    .CntW         (CntW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wkey_o  (mem_wkey),
    .mem_wmode_o (mem_wmode),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rkey_i  (mem_rkey),
    .mem_rmode_i (mem_rmode),
    .mask_cmd_o  (mask_cmd),
    .rd_hit_i    (rd_hit),
    .wr_hit_i    (wr_hit),
    .valid_o     (valid_o),
    .mentioned_o (mentioned),
    .entry_mode_o(entry_mode),
    .status_o    (status),
    .used_o      (used)
  );

  rut_slot_mem #(
    .Depth(VirtualSlots),
    .KeyW (KeyW),
    .AddrW(AddrW)
  ) u_slot_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wkey_i (mem_wkey),
    .wmode_i(mem_wmode),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rkey_o (mem_rkey),
    .rmode_o(mem_rmode)
  );

  rut_masks u_masks (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (mask_cmd),
    .rd_mask_o(rd_mask),
    .wr_mask_o(wr_mask),
    .rd_hit_o (rd_hit),
    .wr_hit_o (wr_hit)
  );

  always_comb begin
    res_o.mentioned       = mentioned;
    res_o.entry_mode      = entry_mode;
    res_o.status          = status;
    res_o.real_read_mask  = rd_mask;
    res_o.real_write_mask = wr_mask;
    res_o.virtual_count   = CountW'(used);
  end

endmodule

### design/rut_slot_mem.sv
`timescale 1ns / 1ps

module rut_slot_mem #(
  parameter int unsigned Depth = 8,
  parameter int unsigned KeyW  = 23,
  parameter int unsigned AddrW = 3
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [KeyW-1:0]  wkey_i,
  input  logic [1:0]       wmode_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [KeyW-1:0]  rkey_o,
  output logic [1:0]       rmode_o
);

  logic [KeyW-1:0] key_mem  [Depth];
  logic [1:0]      mode_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i]  <= wkey_i;
      mode_mem[waddr_i] <= wmode_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rkey_o  <= key_mem[raddr_i];
      rmode_o <= mode_mem[raddr_i];
    end
  end

endmodule

### design/rut_masks.sv
`timescale 1ns / 1ps

module rut_masks
  import rut_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mask_cmd_t        cmd_i,
  output logic [MaskW-1:0] rd_mask_o,
  output logic [MaskW-1:0] wr_mask_o,
  output logic             rd_hit_o,
  output logic             wr_hit_o
);

  logic [MaskW-1:0] rd_q, rd_d;
  logic [MaskW-1:0] wr_q, wr_d;
  logic [MaskW-1:0] onehot;

  assign onehot = MaskW'(1) << cmd_i.bit_idx;

  always_comb begin
    rd_d = rd_q;
    wr_d = wr_q;
    if (cmd_i.apply) begin
      if (cmd_i.clear) begin
        rd_d = '0;
        wr_d = '0;
      end else begin
        if (cmd_i.set_rd) rd_d = rd_q | onehot;
        if (cmd_i.set_wr) wr_d = wr_q | onehot;
      end
    end
  end

  // report bits as they stand after this request
  assign rd_hit_o = cmd_i.idx_ok & rd_d[cmd_i.bit_idx];
  assign wr_hit_o = cmd_i.idx_ok & wr_d[cmd_i.bit_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      wr_q <= '0;
    end else begin
      rd_q <= rd_d;
      wr_q <= wr_d;
    end
  end

  assign rd_mask_o = rd_q;
  assign wr_mask_o = wr_q;

endmodule

### design/rut_seq.sv
`timescale 1ns / 1ps

module rut_seq
  import rut_pkg::*;
#(
  parameter int unsigned VirtualSlots  = VirtualSlotsDef,
  parameter int unsigned RealRegisters = RealRegistersDef,
  parameter int unsigned IndexBits     = IndexBitsDef,
  parameter int unsigned KeyW          = IndexBits + ClassW,
  parameter int unsigned AddrW         = (VirtualSlots > 1) ? $clog2(VirtualSlots) : 1,
  parameter int unsigned CntW          = $clog2(VirtualSlots + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  req_t             req_i,
  output logic             busy_o,
  // slot table
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output logic [KeyW-1:0]  mem_wkey_o,
  output logic [1:0]       mem_wmode_o,
  output logic             mem_re_o,
  output logic [AddrW-1:0] mem_raddr_o,
  input  logic [KeyW-1:0]  mem_rkey_i,
  input  logic [1:0]       mem_rmode_i,
  // real masks
  output mask_cmd_t        mask_cmd_o,
  input  logic             rd_hit_i,
  input  logic             wr_hit_i,
  // result
  output logic             valid_o,
  output logic             mentioned_o,
  output logic [1:0]       entry_mode_o,
  output logic             status_o,
  output logic [CntW-1:0]  used_o
);

  localparam int unsigned ExtW = (IndexBits > ReqIndexW) ? IndexBits : ReqIndexW;
  localparam logic [CntW-1:0]      SlotsMax = CntW'(VirtualSlots);
  localparam logic [ReqIndexW-1:0] RealMax  = ReqIndexW'(RealRegisters);

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  logic [CntW-1:0]  ptr_q, ptr_d;
  logic [CntW-1:0]  used_q, used_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [AddrW-1:0] cmp_idx_q, cmp_idx_d;
  logic             hit_q, hit_d;
  logic [AddrW-1:0] hit_idx_q, hit_idx_d;
  logic [1:0]       hit_mode_q, hit_mode_d;
  logic             valid_q, valid_d;
  logic             ment_q, ment_d;
  logic [1:0]       emode_q, emode_d;
  logic             status_q, status_d;

  logic [ExtW-1:0]  idx_wide;
  logic [KeyW-1:0]  key;
  logic             match;
  logic             issue;
  logic             is_add;
  logic             accept;

  assign idx_wide = ExtW'(req_q.reg_index);
  assign key      = {req_q.reg_class, idx_wide[IndexBits-1:0]};
  assign match    = cmp_vld_q && (mem_rkey_i == key);
  assign issue    = (state_q == ST_SCAN) && (ptr_q < used_q) && !match;
  assign is_add   = (req_q.operation == OP_ADD) && (req_q.access_mode != MODE_ABSENT);
  assign accept   = start_i && (state_q == ST_IDLE);

  assign mem_re_o    = issue;
  assign mem_raddr_o = ptr_q[AddrW-1:0];

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    ptr_d      = ptr_q;
    used_d     = used_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_mode_d = hit_mode_q;
    valid_d    = 1'b0;
    ment_d     = ment_q;
    emode_d    = emode_q;
    status_d   = status_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = hit_idx_q;
    mem_wkey_o  = key;
    mem_wmode_o = req_q.access_mode;

    mask_cmd_o.apply   = 1'b0;
    mask_cmd_o.clear   = (req_q.operation == OP_CLEAR);
    mask_cmd_o.idx_ok  = (req_q.reg_index < RealMax);
    mask_cmd_o.bit_idx = req_q.reg_index[BitIdxW-1:0];
    mask_cmd_o.set_rd  = mask_cmd_o.idx_ok && (req_q.operation == OP_ADD) &&
                         ((req_q.access_mode == MODE_READ) ||
                          (req_q.access_mode == MODE_MODIFY));
    mask_cmd_o.set_wr  = mask_cmd_o.idx_ok && (req_q.operation == OP_ADD) &&
                         ((req_q.access_mode == MODE_WRITE) ||
                          (req_q.access_mode == MODE_MODIFY));

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d = req_i;
          ptr_d = '0;
          hit_d = 1'b0;
          if ((req_i.operation != OP_CLEAR) && req_i.is_virtual && (used_q != '0)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_APPLY;
          end
        end
      end
      ST_SCAN: begin
        // one slot read issued and one compared each cycle
        cmp_vld_d = issue;
        cmp_idx_d = ptr_q[AddrW-1:0];
        if (issue) ptr_d = ptr_q + CntW'(1);
        if (match) begin
          hit_d      = 1'b1;
          hit_idx_d  = cmp_idx_q;
          hit_mode_d = mem_rmode_i;
          state_d    = ST_APPLY;
        end else if (!issue) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_d  = ST_IDLE;
        valid_d  = 1'b1;
        ment_d   = 1'b0;
        emode_d  = MODE_ABSENT;
        status_d = 1'b0;
        if (req_q.operation == OP_CLEAR) begin
          used_d           = '0;
          mask_cmd_o.apply = 1'b1;
        end else if (req_q.is_virtual) begin
          if (hit_q) begin
            ment_d = 1'b1;
            if (is_add && (hit_mode_q != req_q.access_mode)) begin
              mem_we_o    = 1'b1;
              mem_wmode_o = MODE_MODIFY;
              emode_d     = MODE_MODIFY;
            end else begin
              emode_d = hit_mode_q;
            end
          end else if (is_add && (used_q < SlotsMax)) begin
            // append at the first free slot
            mem_we_o    = 1'b1;
            mem_waddr_o = used_q[AddrW-1:0];
            used_d      = used_q + CntW'(1);
            ment_d      = 1'b1;
            emode_d     = req_q.access_mode;
          end else if (is_add) begin
            status_d = 1'b1;
          end
        end else begin
          mask_cmd_o.apply = 1'b1;
          if (rd_hit_i || wr_hit_i) begin
            ment_d = 1'b1;
            if (rd_hit_i && wr_hit_i) emode_d = MODE_MODIFY;
            else if (rd_hit_i)        emode_d = MODE_READ;
            else                      emode_d = MODE_WRITE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      valid_q   <= 1'b0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      ptr_q     <= '0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      valid_q   <= valid_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      ptr_q     <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_mode_q <= hit_mode_d;
    ment_q     <= ment_d;
    emode_q    <= emode_d;
    status_q   <= status_d;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign valid_o      = valid_q;
  assign mentioned_o  = ment_q;
  assign entry_mode_o = emode_q;
  assign status_o     = status_q;
  assign used_o       = used_q;

  a_used_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= SlotsMax)
    else $error("slot count above table size");

  a_valid_after_apply : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q == ST_APPLY))
    else $error("result strobe without apply step");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q) |-> (used_q == SlotsMax))
    else $error("table-full status while slots remain");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("not busy after request accepted");

  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (ptr_q <= used_q))
    else $error("scan pointer past used slots");

endmodule
